### hw/rtl/spim_pkg.sv
// shared types, constants and helper functions for the spi master core
package spim_pkg;

   // word length of one serial transfer
   localparam int unsigned DATA_WIDTH = 8;
   // edges in one transfer and the width of the edge counter
   localparam int unsigned EDGE_TOTAL = 2 * DATA_WIDTH;
   localparam int unsigned EDGE_W     = $clog2(EDGE_TOTAL + 1);
   // prescaler width, enough for the longest half period
   localparam int unsigned PRESCALE_W = 7;

   // request operation codes
   localparam logic [1:0] OP_TICK        = 2'd0;
   localparam logic [1:0] OP_WRITE_DATA  = 2'd1;
   localparam logic [1:0] OP_READ_DATA   = 2'd2;
   localparam logic [1:0] OP_READ_STATUS = 2'd3;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE           = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERRUPT_ENABLE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LSB_FIRST        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_POLARITY   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_PHASE      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_SELECT      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOUBLE_SPEED     = 3'd6;

   // status byte bit positions
   localparam int unsigned STATUS_DONE_BIT      = 7;
   localparam int unsigned STATUS_COLLISION_BIT = 6;
   localparam int unsigned STATUS_SPEED_BIT     = 0;

   // one result beat
   typedef struct packed {
      logic [7:0] read_data;
      logic       done_flag;
      logic       collision_flag;
      logic       sck;
      logic       mosi;
      logic       irq;
      logic       busy_res;
   } rsp_type;

   // log2 of the half period in tick requests, 0 to 6
   function automatic logic [2:0] half_period_log2(input logic [1:0] rate_select,
                                                   input logic       double_speed);
      logic [2:0] base;
      begin
         base = (rate_select == 2'd3) ? 3'd6 : {rate_select, 1'b1};
         return base - {2'b00, double_speed};
      end
   endfunction

endpackage

### hw/rtl/spi_master_peripheral_core.sv
// eight-bit spi master, modes 0 to 3, with a valid/stall bus front end
//
// usage: every request beat on the req_ channel is one bus operation: a clock
// tick that advances the prescaler and the serial clock, a data write that
// starts a transfer, a data read or a status read. each accepted request gives
// exactly one response beat on the rsp_ channel carrying the read byte, the
// flags and the pin levels after that operation.
// the response is registered; while req_stall is low, one request is taken
// every cycle. the response side has an output register and a skid
// register, so a new request is still taken while a response waits; req_stall
// rises only once both are full and falls as soon as the skid empties.
// the configuration port writes one register per cycle with csr_write_en; it
// has no read-back. writing enable to zero aborts a running transfer.
// reset (synchronous, active high) clears all configuration, the shift and
// receive registers and the flags, and empties both response stages; no
// response is pending after reset and req_stall is low.
module spi_master_peripheral_core (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_op,
   input  logic [7:0]                        req_write_data,
   input  logic                              req_miso,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_read_data,
   output logic                              rsp_done_flag,
   output logic                              rsp_collision_flag,
   output logic                              rsp_sck,
   output logic                              rsp_mosi,
   output logic                              rsp_irq,
   output logic                              rsp_busy_res,
   // configuration port
   input  logic                              csr_write_en,
   input  logic [spim_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [1:0]                        csr_write_data
);
   import spim_pkg::*;

   // configuration registers
   logic       enable_ff, interrupt_enable_ff, lsb_first_ff, clock_polarity_ff;
   logic       clock_phase_ff, double_speed_ff;
   logic [1:0] rate_select_ff;

   // transfer state
   logic [DATA_WIDTH-1:0] shift_ff, shift_in;
   logic [DATA_WIDTH-1:0] receive_ff, receive_in;
   logic [EDGE_W-1:0]     edge_ff, edge_in;
   logic [PRESCALE_W-1:0] prescale_ff, prescale_in;
   logic sck_level_ff, sck_level_in, mosi_level_ff, mosi_level_in;
   logic active_ff, active_in, done_ff, done_in, collision_ff, collision_in;
   logic status_seen_ff, status_seen_in;

   // response registers
   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_ff, skid_ff, result;

   logic                  req_accept;
   logic                  abort_xfer;
   logic [PRESCALE_W-1:0] half_period;
   logic [PRESCALE_W:0]   prescale_next;
   logic [EDGE_W-1:0]     edge_next;
   logic                  leading, last_edge, out_bit;
   logic [7:0]            rd;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign abort_xfer = csr_write_en && (csr_index == CSR_ENABLE) && !csr_write_data[0];

   assign half_period   = PRESCALE_W'(1) << half_period_log2(rate_select_ff, double_speed_ff);
   assign prescale_next = {1'b0, prescale_ff} + (PRESCALE_W+1)'(1);
   assign edge_next     = edge_ff + EDGE_W'(1);
   assign leading       = edge_next[0];
   assign last_edge     = edge_next >= EDGE_W'(EDGE_TOTAL);
   assign out_bit       = lsb_first_ff ? shift_ff[0] : shift_ff[DATA_WIDTH-1];

   // next state and result for one request beat
   always_comb begin
      shift_in       = shift_ff;
      receive_in     = receive_ff;
      edge_in        = edge_ff;
      prescale_in    = prescale_ff;
      sck_level_in   = sck_level_ff;
      mosi_level_in  = mosi_level_ff;
      active_in      = active_ff;
      done_in        = done_ff;
      collision_in   = collision_ff;
      status_seen_in = status_seen_ff;
      rd             = 8'd0;
      case (req_op)
         OP_TICK: begin
            if (active_ff) begin
               if (prescale_next < {1'b0, half_period}) begin
                  prescale_in = prescale_next[PRESCALE_W-1:0];
               end else begin
                  prescale_in  = '0;
                  edge_in      = edge_next;
                  sck_level_in = !sck_level_ff;
                  // sample on one edge kind, drive mosi on the other
                  if (leading == !clock_phase_ff) begin
                     if (lsb_first_ff) begin
                        shift_in = {req_miso, shift_ff[DATA_WIDTH-1:1]};
                     end else begin
                        shift_in = {shift_ff[DATA_WIDTH-2:0], req_miso};
                     end
                  end else if (!last_edge) begin
                     mosi_level_in = out_bit;
                  end
                  if (last_edge) begin
                     active_in  = 1'b0;
                     edge_in    = '0;
                     receive_in = shift_in;
                     done_in    = 1'b1;
                  end
               end
            end
         end
         OP_WRITE_DATA: begin
            if (enable_ff) begin
               if (active_ff) begin
                  collision_in = 1'b1;
               end else begin
                  shift_in     = req_write_data;
                  active_in    = 1'b1;
                  edge_in      = '0;
                  prescale_in  = '0;
                  sck_level_in = clock_polarity_ff;
                  if (!clock_phase_ff) begin
                     mosi_level_in = lsb_first_ff ? req_write_data[0]
                                                  : req_write_data[DATA_WIDTH-1];
                  end
               end
            end
         end
         OP_READ_DATA: begin
            rd = receive_ff;
            if (status_seen_ff) begin
               done_in        = 1'b0;
               collision_in   = 1'b0;
               status_seen_in = 1'b0;
            end
         end
         default: begin
            rd                       = 8'd0;
            rd[STATUS_DONE_BIT]      = done_ff;
            rd[STATUS_COLLISION_BIT] = collision_ff;
            rd[STATUS_SPEED_BIT]     = double_speed_ff;
            if (done_ff || collision_ff) begin
               status_seen_in = 1'b1;
            end
         end
      endcase
      result.read_data      = rd;
      result.done_flag      = done_in;
      result.collision_flag = collision_in;
      result.sck            = active_in ? sck_level_in : clock_polarity_ff;
      result.mosi           = mosi_level_in;
      result.irq            = done_in && interrupt_enable_ff;
      result.busy_res       = active_in;
   end

   // transfer state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff           <= 1'b0;
         interrupt_enable_ff <= 1'b0;
         lsb_first_ff        <= 1'b0;
         clock_polarity_ff   <= 1'b0;
         clock_phase_ff      <= 1'b0;
         rate_select_ff      <= 2'd0;
         double_speed_ff     <= 1'b0;
         shift_ff            <= '0;
         receive_ff          <= '0;
         edge_ff             <= '0;
         prescale_ff         <= '0;
         sck_level_ff        <= 1'b0;
         mosi_level_ff       <= 1'b0;
         active_ff           <= 1'b0;
         done_ff             <= 1'b0;
         collision_ff        <= 1'b0;
         status_seen_ff      <= 1'b0;
      end else begin
         if (req_accept) begin
            shift_ff       <= shift_in;
            receive_ff     <= receive_in;
            sck_level_ff   <= sck_level_in;
            mosi_level_ff  <= mosi_level_in;
            done_ff        <= done_in;
            collision_ff   <= collision_in;
            status_seen_ff <= status_seen_in;
         end
         // disable aborts a running transfer
         if (abort_xfer) begin
            active_ff   <= 1'b0;
            edge_ff     <= '0;
            prescale_ff <= '0;
         end else if (req_accept) begin
            active_ff   <= active_in;
            edge_ff     <= edge_in;
            prescale_ff <= prescale_in;
         end
         // register writes
         if (csr_write_en) begin
            case (csr_index)
               CSR_ENABLE:           enable_ff           <= csr_write_data[0];
               CSR_INTERRUPT_ENABLE: interrupt_enable_ff <= csr_write_data[0];
               CSR_LSB_FIRST:        lsb_first_ff        <= csr_write_data[0];
               CSR_CLOCK_POLARITY:   clock_polarity_ff   <= csr_write_data[0];
               CSR_CLOCK_PHASE:      clock_phase_ff      <= csr_write_data[0];
               CSR_RATE_SELECT:      rate_select_ff      <= csr_write_data;
               CSR_DOUBLE_SPEED:     double_speed_ff     <= csr_write_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   // output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_valid_ff && rsp_stall) begin
         if (req_accept) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         out_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= req_accept;
      end
   end

   // response beat payload
   always_ff @(posedge clock) begin
      if (out_valid_ff && rsp_stall) begin
         if (req_accept) begin
            skid_ff <= result;
         end
      end else if (skid_valid_ff) begin
         out_ff <= skid_ff;
      end else if (req_accept) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_read_data      = out_ff.read_data;
   assign rsp_done_flag      = out_ff.done_flag;
   assign rsp_collision_flag = out_ff.collision_flag;
   assign rsp_sck            = out_ff.sck;
   assign rsp_mosi           = out_ff.mosi;
   assign rsp_irq            = out_ff.irq;
   assign rsp_busy_res       = out_ff.busy_res;

endmodule
